/* hdl/rrp_pkg.sv */
// Shared types and constants for the receive ring read pointer engine.
package rrp_pkg;

  localparam logic [16:0] RING_BASE  = 17'd8192;
  localparam logic [15:0] HDR_BYTES  = 16'd4;
  localparam logic [15:0] CRC_BYTES  = 16'd4;
  localparam logic [15:0] CAPR_BIAS  = 16'h10;
  localparam int          ROK_BIT    = 0;
  localparam int          QUEUE_DEPTH = 2;
  localparam int          QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int          QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic REG_RING_SIZE = 1'b0;

  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_NO_ROK  = 2'd1,
    RES_BAD_LEN = 2'd2
  } rrp_res_t;

  typedef struct packed {
    rrp_res_t    res;
    logic [15:0] off;
    logic [15:0] len;
    logic        wrap;
    logic [16:0] split;
    logic [16:0] next;
  } rrp_entry_t;

endpackage

/* hdl/rrp_front.sv */
// Front end: classifies each header request and advances the read offset.
module rrp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          ring_size_index,
  input  logic [15:0]         header_status,
  input  logic [15:0]         packet_length,
  input  logic                first_of_interrupt,
  output rrp_pkg::rrp_entry_t entry
);
  import rrp_pkg::*;

  logic [16:0] read_offset;
  logic [16:0] read_offset_next;
  logic [16:0] ring;
  logic [15:0] off_eff;
  logic [16:0] hdr_end;
  logic [17:0] pkt_end;
  logic        wrap;
  logic [16:0] split;
  logic [16:0] rem;
  logic [16:0] next_raw;
  logic [16:0] next_al;
  logic        rok_fail;
  logic        len_bad;
  rrp_res_t    res;

  always_comb begin
    ring     = RING_BASE << ring_size_index;
    off_eff  = (read_offset >= ring) ? 16'd0 : read_offset[15:0];
    hdr_end  = {1'b0, off_eff} + {1'b0, HDR_BYTES};
    pkt_end  = {1'b0, hdr_end} + {2'b00, packet_length};
    wrap     = pkt_end > {1'b0, ring};
    split    = ring - hdr_end;
    rem      = {1'b0, packet_length} - split;
    next_raw = wrap ? rem : pkt_end[16:0];
    next_al  = (next_raw + 17'd3) & ~17'd3;
    rok_fail = first_of_interrupt && !header_status[ROK_BIT];
    len_bad  = (packet_length <= CRC_BYTES) || ({1'b0, packet_length} > ring);
    if (rok_fail) begin
      res = RES_NO_ROK;
    end else if (len_bad) begin
      res = RES_BAD_LEN;
    end else begin
      res = RES_OK;
    end
    entry.res   = res;
    entry.off   = off_eff;
    entry.len   = packet_length;
    entry.wrap  = wrap;
    entry.split = split;
    entry.next  = next_al;
    read_offset_next = (accept && res == RES_OK) ? next_al : read_offset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_offset <= '0;
    end else begin
      read_offset <= read_offset_next;
    end
  end

endmodule

/* hdl/rrp_queue.sv */
// Short queue of classified requests between front and back end.
module rrp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  rrp_pkg::rrp_entry_t wr_data,
  input  logic                rd,
  output rrp_pkg::rrp_entry_t rd_data,
  output logic                full,
  output logic                empty
);
  import rrp_pkg::*;

  rrp_entry_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign full    = count == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(do_wr) - QCNT_W'(do_rd);
    end
  end

endmodule

/* hdl/rrp_back.sv */
// Back end: builds copy segments and CAPR, holds the result register.
module rrp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  rrp_pkg::rrp_entry_t q_data,
  output logic                q_rd,
  input  logic                pop,
  output logic                empty,
  output logic [1:0]          result_status,
  output logic [15:0]         first_copy_offset,
  output logic [15:0]         first_copy_length,
  output logic [15:0]         second_copy_length,
  output logic [15:0]         second_copy_dest,
  output logic [15:0]         payload_length,
  output logic                wrapped,
  output logic [15:0]         capr_value
);
  import rrp_pkg::*;

  logic        out_valid;
  logic        load;
  logic        ok;
  logic [15:0] pay;
  logic [16:0] rem;
  logic        crc_only;
  logic [15:0] c_off, c_len1, c_len2, c_dest, capr;

  assign load  = !q_empty && (!out_valid || pop);
  assign q_rd  = load;
  assign empty = !out_valid;

  always_comb begin
    ok       = q_data.res == RES_OK;
    pay      = q_data.len - CRC_BYTES;
    rem      = {1'b0, q_data.len} - q_data.split;
    crc_only = rem <= {1'b0, CRC_BYTES};
    c_off    = q_data.off + HDR_BYTES;
    capr     = q_data.next[15:0] - CAPR_BIAS;
    c_dest   = '0;
    c_len2   = '0;
    c_len1   = pay;
    if (q_data.wrap) begin
      c_dest = q_data.split[15:0];
      if (!crc_only) begin
        c_len1 = q_data.split[15:0];
        c_len2 = pay - q_data.split[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_status      <= q_data.res;
      first_copy_offset  <= ok ? c_off  : '0;
      first_copy_length  <= ok ? c_len1 : '0;
      second_copy_length <= ok ? c_len2 : '0;
      second_copy_dest   <= ok ? c_dest : '0;
      payload_length     <= ok ? pay    : '0;
      wrapped            <= ok && q_data.wrap;
      capr_value         <= ok ? capr   : '0;
    end
  end

endmodule

/* hdl/rx_ring_read_pointer_engine.sv */
// Top level: config register, front end, request queue and back end.
// An accepted request is written into the queue, then loaded into the result register.
// Throughput: one request per cycle while the queue is not full; the read offset is
// registered in the front end; the two-entry queue and result register absorb stalls.
// Reset: read offset 0, ring size index 1, queue and result register empty.
module rx_ring_read_pointer_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] header_status,
  input  logic [15:0] packet_length,
  input  logic        first_of_interrupt,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_status,
  output logic [15:0] first_copy_offset,
  output logic [15:0] first_copy_length,
  output logic [15:0] second_copy_length,
  output logic [15:0] second_copy_dest,
  output logic [15:0] payload_length,
  output logic        wrapped,
  output logic [15:0] capr_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rrp_pkg::*;

  logic       [1:0] ring_size_index;
  logic             accept;
  logic             q_rd;
  logic             q_empty;
  rrp_entry_t       f_entry;
  rrp_entry_t       q_data;

  assign pready = 1'b1;
  assign accept = push && !full;
  assign prdata = (paddr[2] == REG_RING_SIZE) ? {30'd0, ring_size_index} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size_index <= 2'd1;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_RING_SIZE) begin
      ring_size_index <= pwdata[1:0];
    end
  end

  rrp_front u_front (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .ring_size_index    (ring_size_index),
    .header_status      (header_status),
    .packet_length      (packet_length),
    .first_of_interrupt (first_of_interrupt),
    .entry              (f_entry)
  );

  rrp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_data (f_entry),
    .rd      (q_rd),
    .rd_data (q_data),
    .full    (full),
    .empty   (q_empty)
  );

  rrp_back u_back (
    .clk                (clk),
    .rst                (rst),
    .q_empty            (q_empty),
    .q_data             (q_data),
    .q_rd               (q_rd),
    .pop                (pop),
    .empty              (empty),
    .result_status      (result_status),
    .first_copy_offset  (first_copy_offset),
    .first_copy_length  (first_copy_length),
    .second_copy_length (second_copy_length),
    .second_copy_dest   (second_copy_dest),
    .payload_length     (payload_length),
    .wrapped            (wrapped),
    .capr_value         (capr_value)
  );

endmodule
